FILE: hdl/turn_hazard_brake_lamp_controller_unit_assert.svh
// assertion macros used by the lamp controller sequencer
`ifndef TURN_HAZARD_BRAKE_LAMP_CONTROLLER_UNIT_ASSERT_SVH
`define TURN_HAZARD_BRAKE_LAMP_CONTROLLER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// checked property, masked while reset is asserted
`define THBLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked property, also checked during reset
`define THBLC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define THBLC_ASSERT(lbl, prop, msg)
`define THBLC_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

FILE: hdl/thblc_pkg.sv
`default_nettype none

package thblc_pkg;

  // default depth of the brake sample window
  localparam int DEF_WINDOW = 8;

  // brake threshold after reset
  localparam logic [7:0] BRAKE_THRESHOLD_RST = 8'd45;

  // one input item: switch states and one brake sample
  typedef struct packed {
    logic       hazard_req;
    logic       right_req;
    logic       left_req;
    logic       regen_active;
    logic [7:0] brake_sample;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic       left_lamp;
    logic       right_lamp;
    logic       tail_lamp;
    logic [7:0] brake_average;
  } out_item_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept_ready;
    logic update;
    logic average;
    logic present;
  } ctrl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic in_valid;
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

FILE: hdl/thblc_in_if.sv
`default_nettype none

interface thblc_in_if;
  import thblc_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/thblc_out_if.sv
`default_nettype none

interface thblc_out_if;
  import thblc_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/thblc_cfg_if.sv
`default_nettype none

interface thblc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/thblc_ctrl.sv
`default_nettype none
`include "turn_hazard_brake_lamp_controller_unit_assert.svh"

module thblc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  thblc_pkg::ctrl_sts_t  sts_i,
  output thblc_pkg::ctrl_cmd_t  cmd_o
);
  import thblc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_AVG,
    S_OUT
  } state_e;

  state_e     state_q;
  ctrl_cmd_t  cmd_q;

  // sequencer: take an item, update ring and sum, average, hand over result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q            <= S_IDLE;
      cmd_q.accept_ready <= 1'b1;
      cmd_q.update       <= 1'b0;
      cmd_q.average      <= 1'b0;
      cmd_q.present      <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (sts_i.in_valid && cmd_q.accept_ready) begin
            state_q            <= S_UPDATE;
            cmd_q.accept_ready <= 1'b0;
            cmd_q.update       <= 1'b1;
          end
        end
        S_UPDATE: begin
          state_q       <= S_AVG;
          cmd_q.update  <= 1'b0;
          cmd_q.average <= 1'b1;
        end
        S_AVG: begin
          state_q       <= S_OUT;
          cmd_q.average <= 1'b0;
          cmd_q.present <= 1'b1;
        end
        S_OUT: begin
          if (sts_i.out_free) begin
            state_q            <= S_IDLE;
            cmd_q.present      <= 1'b0;
            cmd_q.accept_ready <= 1'b1;
          end
        end
        default: begin
          state_q            <= S_IDLE;
          cmd_q.accept_ready <= 1'b1;
          cmd_q.update       <= 1'b0;
          cmd_q.average      <= 1'b0;
          cmd_q.present      <= 1'b0;
        end
      endcase
    end
  end

  assign cmd_o = cmd_q;

  // checks
  `THBLC_ASSERT(a_one_item, (sts_i.in_valid && cmd_q.accept_ready) |=> !cmd_q.accept_ready, "second item taken while one is in flight")
  `THBLC_ASSERT(a_update_then_avg, cmd_q.update |=> cmd_q.average, "average step did not follow update")
  `THBLC_ASSERT(a_cmd_onehot, $onehot({cmd_q.accept_ready, cmd_q.update, cmd_q.average, cmd_q.present}), "controller commands overlap")

endmodule

`default_nettype wire

FILE: hdl/thblc_datapath.sv
`default_nettype none

module thblc_datapath #(
  parameter int WINDOW = thblc_pkg::DEF_WINDOW
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  thblc_pkg::ctrl_cmd_t  cmd_i,
  output thblc_pkg::ctrl_sts_t  sts_o,
  input  logic                  cfg_valid_i,
  input  logic [7:0]            cfg_data_i,
  input  logic                  in_valid_i,
  input  thblc_pkg::in_item_t   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output thblc_pkg::out_item_t  out_data_o
);
  import thblc_pkg::*;

  localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W  = $clog2(255 * WINDOW + 1);
  localparam int CLOG_W = $clog2(WINDOW);
  // reciprocal of the window depth, exact for every sum below 2**SUM_W
  localparam int SHIFT  = SUM_W + CLOG_W;
  localparam int REC_W  = SUM_W + 1;
  localparam int PROD_W = SUM_W + REC_W;
  localparam logic [REC_W-1:0] RECIP = REC_W'(((1 << SHIFT) + WINDOW - 1) / WINDOW);

  logic [7:0]        ring_mem [WINDOW];
  logic [WINDOW-1:0] vld_q;
  logic [PTR_W-1:0]  ptr_q;
  logic [SUM_W-1:0]  sum_q;
  logic [SUM_W-1:0]  sum_d;
  logic [7:0]        old_q;
  logic              old_vld_q;
  logic [7:0]        old_val;
  in_item_t          item_q;
  logic              left_q, right_q;
  logic              left_d, right_d;
  logic [7:0]        thr_q;
  logic [PROD_W-1:0] prod;
  logic [7:0]        avg_q;
  logic              force_on;
  logic              capture;
  logic              out_free;
  logic              out_valid_q;
  out_item_t         out_q;

  assign capture  = in_valid_i && cmd_i.accept_ready;
  assign out_free = !out_valid_q || out_ready_i;

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= BRAKE_THRESHOLD_RST;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  // item capture and read of the oldest sample
  always_ff @(posedge clk_i) begin
    if (capture) begin
      item_q <= in_data_i;
      old_q  <= ring_mem[ptr_q];
    end
  end

  // sample ring write
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      ring_mem[ptr_q] <= item_q.brake_sample;
    end
  end

  // never-written entries count as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      old_vld_q <= 1'b0;
    end else if (capture) begin
      old_vld_q <= vld_q[ptr_q];
    end
  end

  assign old_val = old_vld_q ? old_q : 8'd0;
  assign sum_d   = sum_q - SUM_W'(old_val) + SUM_W'(item_q.brake_sample);

  // indicator toggles for this tick
  always_comb begin
    if (item_q.hazard_req) begin
      left_d  = !left_q;
      right_d = !left_q;
    end else begin
      right_d = item_q.right_req ? !right_q : 1'b0;
      if (!item_q.right_req && item_q.left_req) begin
        left_d = !left_q;
      end else begin
        left_d = item_q.left_req ? left_q : 1'b0;
      end
    end
  end

  // mean by reciprocal multiply
  assign prod     = PROD_W'(sum_q) * PROD_W'(RECIP);
  assign force_on = (avg_q > thr_q) || item_q.regen_active;

  // ring pointer, running sum, lamp state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      ptr_q       <= '0;
      sum_q       <= '0;
      left_q      <= 1'b0;
      right_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.update) begin
        vld_q[ptr_q] <= 1'b1;
        sum_q        <= sum_d;
        left_q       <= left_d;
        right_q      <= right_d;
        if (ptr_q == PTR_W'(WINDOW - 1)) begin
          ptr_q <= '0;
        end else begin
          ptr_q <= ptr_q + PTR_W'(1);
        end
      end
      if (cmd_i.present && out_free) begin
        out_valid_q <= 1'b1;
        if (force_on) begin
          left_q  <= 1'b1;
          right_q <= 1'b1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // average register
  always_ff @(posedge clk_i) begin
    if (cmd_i.average) begin
      avg_q <= prod[SHIFT +: 8];
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.present && out_free) begin
      out_q.left_lamp     <= left_q || force_on;
      out_q.right_lamp    <= right_q || force_on;
      out_q.tail_lamp     <= force_on;
      out_q.brake_average <= avg_q;
    end
  end

  assign sts_o.in_valid = in_valid_i;
  assign sts_o.out_free = out_free;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule

`default_nettype wire

FILE: hdl/turn_hazard_brake_lamp_controller_unit.sv
// turn, hazard and brake lamp controller
//
// in_i carries one blink tick per item: hazard, right, left and regen switch
// states plus one raw brake pressure sample. out_o returns exactly one item
// per tick: both indicator drives, the tail lamp and the mean of the last
// WINDOW brake samples. cfg_i writes the brake threshold and is always ready;
// write it only while no tick is in flight.
//
// an item passes these steps from acceptance to its result being valid on out_o:
// the oldest sample is read at acceptance, then ring write with running sum
// update, reciprocal multiply for the mean, result load. a new tick is taken
// only after the result is loaded, so one item is in flight at a time, set by
// the four steps of the sequencer; the load waits for a free output register.
//
// reset puts lamps off, threshold at 45, the sum and pointer at zero and
// marks every ring entry empty (an empty entry reads as zero), at once.
// if the receiver stalls, the result holds in the output register; one more
// tick is still taken and its result waits until the register frees.
`default_nettype none

module turn_hazard_brake_lamp_controller_unit #(
  parameter int WINDOW = thblc_pkg::DEF_WINDOW
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  thblc_cfg_if.sink    cfg_i,
  thblc_in_if.sink     in_i,
  thblc_out_if.source  out_o
);
  import thblc_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = cmd.accept_ready;

  // sequencer
  thblc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // ring, sum, lamp state and result register
  thblc_datapath #(
    .WINDOW (WINDOW)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .in_valid_i  (in_i.valid),
    .in_data_i   (in_i.data),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );

endmodule

`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import thblc_pkg::*;

  localparam int          WINDOW       = DEF_WINDOW;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 12;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  thblc_cfg_if cfg_bus ();
  thblc_in_if  tick_bus ();
  thblc_out_if lamp_bus ();

  turn_hazard_brake_lamp_controller_unit #(
    .WINDOW (WINDOW)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (tick_bus),
    .out_o  (lamp_bus)
  );

  // clock
  always #2 clk_i = ~clk_i;

  // lamp model state, mirrors the block after reset
  logic        model_left      = 1'b0;
  logic        model_right     = 1'b0;
  logic [7:0]  sample_window [WINDOW] = '{default: 8'd0};
  int unsigned window_ptr      = 0;
  int unsigned window_sum      = 0;
  logic [7:0]  model_threshold = BRAKE_THRESHOLD_RST;

  out_item_t   expected_lamps [$];
  int unsigned sent_count    = 0;
  int unsigned checked_count = 0;
  int unsigned error_count   = 0;
  int unsigned cycle_count   = 0;
  bit          idle_on       = 1'b1;
  int unsigned hold_request  = 0;

  // advance the lamp model by one blink tick
  function automatic out_item_t predict_lamps(input in_item_t t);
    out_item_t   r;
    int unsigned avg;
    if (t.hazard_req) begin
      if (model_left) begin
        model_left  = 1'b0;
        model_right = 1'b0;
      end else begin
        model_left  = 1'b1;
        model_right = 1'b1;
      end
    end else if (t.right_req) begin
      model_right = ~model_right;
    end else if (t.left_req) begin
      model_left = ~model_left;
    end
    if (!t.hazard_req && !t.right_req) model_right = 1'b0;
    if (!t.hazard_req && !t.left_req)  model_left  = 1'b0;
    // ring update and truncated mean
    window_sum = window_sum - sample_window[window_ptr] + t.brake_sample;
    sample_window[window_ptr] = t.brake_sample;
    window_ptr = (window_ptr + 1) % WINDOW;
    avg = window_sum / WINDOW;
    // brake lamps force both indicators on and keep them as lamp state
    if (avg > model_threshold || t.regen_active) begin
      model_left  = 1'b1;
      model_right = 1'b1;
      r.tail_lamp = 1'b1;
    end else begin
      r.tail_lamp = 1'b0;
    end
    r.left_lamp     = model_left;
    r.right_lamp    = model_right;
    r.brake_average = avg[7:0];
    return r;
  endfunction

  function automatic in_item_t make_tick(input logic h, input logic rr, input logic lr,
                                         input logic g, input logic [7:0] s);
    in_item_t t;
    t.hazard_req   = h;
    t.right_req    = rr;
    t.left_req     = lr;
    t.regen_active = g;
    t.brake_sample = s;
    return t;
  endfunction

  // gap length, mostly short with a few long ones
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  // random tick, samples clustered around the threshold so the mean crosses it
  function automatic in_item_t random_tick(input logic [7:0] thr);
    int          s;
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      s = int'(thr) + int'($urandom_range(0, 20)) - 10;
      if (s < 0)   s = 0;
      if (s > 255) s = 255;
    end else if (r < 6) begin
      s = ($urandom_range(0, 1) != 0) ? 255 : 0;
    end else begin
      s = $urandom_range(0, 255);
    end
    return make_tick($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0, s[7:0]);
  endfunction

  // cycle limit
  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // accepted config writes and ticks feed the model
  always @(posedge clk_i) begin : tick_monitor
    if (rst_ni) begin
      if (cfg_bus.valid && cfg_bus.ready) model_threshold = cfg_bus.data;
      if (tick_bus.valid && tick_bus.ready) expected_lamps.push_back(predict_lamps(tick_bus.data));
    end
  end

  // compare each accepted result with the oldest expected one
  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && lamp_bus.valid && lamp_bus.ready) begin
      checked_count++;
      if (expected_lamps.size() == 0) begin
        $error("result item with no tick pending: %p", lamp_bus.data);
        error_count++;
      end else begin
        want = expected_lamps.pop_front();
        if (lamp_bus.data.left_lamp !== want.left_lamp) begin
          $error("left_lamp: expected %0d, got %0d", want.left_lamp, lamp_bus.data.left_lamp);
          error_count++;
        end
        if (lamp_bus.data.right_lamp !== want.right_lamp) begin
          $error("right_lamp: expected %0d, got %0d", want.right_lamp, lamp_bus.data.right_lamp);
          error_count++;
        end
        if (lamp_bus.data.tail_lamp !== want.tail_lamp) begin
          $error("tail_lamp: expected %0d, got %0d", want.tail_lamp, lamp_bus.data.tail_lamp);
          error_count++;
        end
        if (lamp_bus.data.brake_average !== want.brake_average) begin
          $error("brake_average: expected %0d, got %0d", want.brake_average,
                 lamp_bus.data.brake_average);
          error_count++;
        end
      end
    end
  end

  // result receiver with random stalls and long hold-offs on request
  initial begin : lamp_receiver
    int unsigned n;
    lamp_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        lamp_bus.ready <= 1'b0;
        n = hold_request;
        hold_request = 0;
        repeat (n - 1) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        lamp_bus.ready <= 1'b0;
        n = pick_gap();
        repeat (n - 1) @(posedge clk_i);
      end else begin
        lamp_bus.ready <= 1'b1;
      end
    end
  end

  // offer one tick, sometimes after a random gap, and wait until it is taken
  task automatic send_tick(input in_item_t t);
    int unsigned gap;
    gap = (idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap != 0) begin
      tick_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    tick_bus.valid <= 1'b1;
    tick_bus.data  <= t;
    do @(posedge clk_i); while (!tick_bus.ready);
    sent_count++;
  endtask

  // wait until every tick has its result, then let the pipeline settle
  task automatic wait_drained();
    tick_bus.valid <= 1'b0;
    while (checked_count != sent_count) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [7:0] value);
    wait_drained();
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
  endtask

  // hazard, turn and regen behaviour at the default threshold
  task automatic test_indicator_logic();
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 8'd0));
    send_tick(make_tick(1'b1, 1'b0, 1'b0, 1'b0, 8'd0));   // hazard, both on
    send_tick(make_tick(1'b1, 1'b1, 1'b1, 1'b0, 8'd0));   // hazard with left on, both off
    send_tick(make_tick(1'b1, 1'b0, 1'b1, 1'b0, 8'd0));
    send_tick(make_tick(1'b0, 1'b1, 1'b0, 1'b0, 8'd0));   // right toggles off
    send_tick(make_tick(1'b0, 1'b1, 1'b0, 1'b0, 8'd0));   // right toggles on
    send_tick(make_tick(1'b0, 1'b0, 1'b1, 1'b0, 8'd0));   // left on, right cleared
    send_tick(make_tick(1'b0, 1'b1, 1'b1, 1'b0, 8'd0));   // both requested, left holds
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b1, 8'd0));   // regen forces lamps
    send_tick(make_tick(1'b1, 1'b0, 1'b0, 1'b0, 8'd0));   // forced left seen by hazard
  endtask

  // mean equal to the threshold must not light the brake lamps
  task automatic test_threshold_extremes();
    write_threshold(8'd255);
    repeat (WINDOW) send_tick(make_tick(1'b0, 1'b1, 1'b0, 1'b0, 8'd255));
    write_threshold(8'd0);
    repeat (WINDOW) send_tick(make_tick(1'b0, 1'b0, 1'b1, 1'b0, 8'd0));
  endtask

  // receiver holds off while the sender keeps offering ticks
  task automatic test_input_backpressure();
    write_threshold(BRAKE_THRESHOLD_RST);
    idle_on = 1'b0;
    hold_request = 300;
    repeat (30) send_tick(random_tick(model_threshold));
    idle_on = 1'b1;
  endtask

  // random traffic over several thresholds, one phase without idling
  task automatic test_random_traffic();
    logic [7:0] thr_set [5];
    thr_set = '{8'($urandom_range(0, 255)), 8'd0, 8'd255, BRAKE_THRESHOLD_RST,
                8'($urandom_range(0, 255))};
    foreach (thr_set[p]) begin
      write_threshold(thr_set[p]);
      idle_on = (p != 3);
      repeat (280) send_tick(random_tick(thr_set[p]));
    end
    idle_on = 1'b1;
  endtask

  initial begin : main_sequence
    cfg_bus.valid  <= 1'b0;
    cfg_bus.data   <= '0;
    tick_bus.valid <= 1'b0;
    tick_bus.data  <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_indicator_logic();
    test_threshold_extremes();
    test_input_backpressure();
    test_random_traffic();

    wait_drained();
    if (error_count == 0 && expected_lamps.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/thblc_pkg.sv
hdl/thblc_in_if.sv
hdl/thblc_out_if.sv
hdl/thblc_cfg_if.sv
hdl/thblc_ctrl.sv
hdl/thblc_datapath.sv
hdl/turn_hazard_brake_lamp_controller_unit.sv
dv/testbench.sv
